// ----- rtl/core/cbm_pkg.sv -----
// ----------------------------------------------------------------------------
// cbm_pkg
// Shared types, codes and constants of the cartridge bank mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package cbm_pkg;

  localparam int unsigned ADDR_W         = 18;
  localparam int unsigned BUS_ADDR_W     = 16;
  localparam int unsigned BUS_DATA_W     = 8;
  localparam int unsigned FUNC_W         = 3;
  localparam int unsigned CHR_BANKS      = 8;
  localparam int unsigned CHR_SEL_W      = $clog2(CHR_BANKS);
  localparam int unsigned PRG_BANK_W     = 4;
  localparam int unsigned IRQ_CNT_W      = 16;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CFG_DATA_W     = 18;
  localparam int unsigned IN_TDATA_W     = 32;
  localparam int unsigned OUT_TDATA_W    = 24;
  localparam int unsigned ROM_ADDR_BITS_DEF = 18;

  // bus access kinds
  localparam logic [FUNC_W-1:0] FUNC_CPU_RD = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_CPU_WR = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_CHR_RD = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_CHR_WR = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_NT     = 3'd4;

  // mapper register offsets (bus_addr[3:0]); offsets below 8 select a pattern bank
  localparam logic [3:0] REG_PRG_BANK  = 4'h8;
  localparam logic [3:0] REG_MIRROR    = 4'h9;
  localparam logic [3:0] REG_IRQ_ACK   = 4'hA;
  localparam logic [3:0] REG_RELOAD_LO = 4'hB;
  localparam logic [3:0] REG_RELOAD_HI = 4'hC;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PRG_MASK   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHR_MASK   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHR_IS_RAM = 2'd2;

  // nametable mirroring modes
  localparam logic [1:0] MIRROR_VERT   = 2'd0;
  localparam logic [1:0] MIRROR_HORZ   = 2'd1;
  localparam logic [1:0] MIRROR_ONE_LO = 2'd2;
  localparam logic [1:0] MIRROR_ONE_HI = 2'd3;

  localparam logic [PRG_BANK_W-1:0] FIXED_PRG_BANK = 4'hF;

  typedef struct packed {
    logic [ADDR_W-1:0] prg_mask;
    logic [ADDR_W-1:0] chr_mask;
    logic              chr_is_ram;
  } cbm_cfg_t;

  typedef struct packed {
    logic [CHR_BANKS-1:0][7:0] pattern_bank;
    logic [PRG_BANK_W-1:0]     prog_bank;
    logic [1:0]                mirror;
    logic                      irq_en;
    logic [IRQ_CNT_W-1:0]      irq_cnt;
    logic [IRQ_CNT_W-1:0]      irq_reload;
    logic                      irq_level;
  } cbm_state_t;

  // mask of the low rom_bits bits of an address
  function automatic logic [ADDR_W-1:0] rom_mask(input int unsigned rom_bits);
    logic [ADDR_W-1:0] m;
    m = '0;
    for (int unsigned i = 0; i < ADDR_W; i++) begin
      m[i] = (i < rom_bits);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/cbm_state.sv -----
// ----------------------------------------------------------------------------
// cbm_state
// Mapper registers and IRQ down-counter, updated once per accepted bus access.
// ----------------------------------------------------------------------------
`default_nettype none

module cbm_state (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              fire_i,
  input  wire logic [cbm_pkg::FUNC_W-1:0]        func_i,
  input  wire logic [cbm_pkg::BUS_ADDR_W-1:0]    bus_addr_i,
  input  wire logic [cbm_pkg::BUS_DATA_W-1:0]    bus_data_i,
  output cbm_pkg::cbm_state_t                    state_o,
  output logic                                   irq_level_d_o
);
  import cbm_pkg::*;

  cbm_state_t st_q, st_d;
  logic       cpu_access;
  logic       reg_hit;
  logic [3:0] offset;

  assign cpu_access = (func_i == FUNC_CPU_RD) || (func_i == FUNC_CPU_WR);
  assign reg_hit    = bus_addr_i[15] || (bus_addr_i[14] && bus_addr_i[13]);
  assign offset     = bus_addr_i[3:0];

  always_comb begin
    st_d = st_q;
    if (fire_i && cpu_access && st_q.irq_en) begin
      st_d.irq_cnt = st_q.irq_cnt - 1'b1;
      // wrap past zero: raise the line and stop counting
      if (st_q.irq_cnt == '0) begin
        st_d.irq_level = 1'b1;
        st_d.irq_en    = 1'b0;
      end
    end
    if (fire_i && (func_i == FUNC_CPU_WR) && reg_hit) begin
      if (!offset[3]) begin
        st_d.pattern_bank[offset[CHR_SEL_W-1:0]] = bus_data_i;
      end else begin
        unique case (offset)
          REG_PRG_BANK:  st_d.prog_bank = bus_data_i[PRG_BANK_W-1:0];
          REG_MIRROR:    st_d.mirror    = bus_data_i[1:0];
          REG_IRQ_ACK: begin
            st_d.irq_level = 1'b0;
            st_d.irq_en    = bus_data_i[0];
            st_d.irq_cnt   = st_q.irq_reload;
          end
          REG_RELOAD_LO: st_d.irq_reload[7:0]  = bus_data_i;
          REG_RELOAD_HI: st_d.irq_reload[15:8] = bus_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else begin
      st_q <= st_d;
    end
  end

  assign state_o       = st_q;
  assign irq_level_d_o = st_d.irq_level;

`ifndef NO_ASSERTIONS
  // the timer clears enable when it raises the line, and acknowledge clears the line
  a_level_excl_en: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(st_q.irq_level && st_q.irq_en))
    else $error("irq line high while counter enabled");

  a_pattern_bank_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && (func_i == FUNC_CPU_WR) && reg_hit && !offset[3])
    |=> (st_q.pattern_bank[$past(offset[CHR_SEL_W-1:0])] == $past(bus_data_i)))
    else $error("pattern bank write lost");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/cbm_xlate.sv -----
// ----------------------------------------------------------------------------
// cbm_xlate
// Address translation of one bus access from the current mapper state.
// ----------------------------------------------------------------------------
`default_nettype none

module cbm_xlate #(
  parameter int unsigned ROM_ADDR_BITS = cbm_pkg::ROM_ADDR_BITS_DEF
) (
  input  wire logic [cbm_pkg::FUNC_W-1:0]     func_i,
  input  wire logic [cbm_pkg::BUS_ADDR_W-1:0] bus_addr_i,
  input  wire cbm_pkg::cbm_state_t            state_i,
  input  wire cbm_pkg::cbm_cfg_t              cfg_i,
  output logic [cbm_pkg::ADDR_W-1:0]          mem_addr_o,
  output logic                                mem_valid_o
);
  import cbm_pkg::*;

  localparam logic [ADDR_W-1:0] RomMask = rom_mask(ROM_ADDR_BITS);

  logic [PRG_BANK_W-1:0] prog_bank;
  logic [ADDR_W-1:0]     prg_addr;
  logic [ADDR_W-1:0]     chr_addr;
  logic [ADDR_W-1:0]     nt_addr;
  logic [7:0]            pattern_bank;

  assign prog_bank = bus_addr_i[14] ? FIXED_PRG_BANK : state_i.prog_bank;
  assign prg_addr  = {prog_bank, bus_addr_i[13:0]} & cfg_i.prg_mask & RomMask;

  assign pattern_bank = state_i.pattern_bank[bus_addr_i[12:10]];
  assign chr_addr     = {pattern_bank, bus_addr_i[9:0]} & cfg_i.chr_mask & RomMask;

  always_comb begin
    nt_addr = '0;
    unique case (state_i.mirror)
      MIRROR_VERT:   nt_addr[10:0] = {bus_addr_i[10], bus_addr_i[9:0]};
      MIRROR_HORZ:   nt_addr[10:0] = {bus_addr_i[11], bus_addr_i[9:0]};
      MIRROR_ONE_LO: nt_addr[10:0] = {1'b0, bus_addr_i[9:0]};
      MIRROR_ONE_HI: nt_addr[10:0] = {1'b1, bus_addr_i[9:0]};
      default:       nt_addr = '0;
    endcase
  end

  always_comb begin
    mem_addr_o  = '0;
    mem_valid_o = 1'b0;
    unique case (func_i)
      FUNC_CPU_RD: begin
        if (bus_addr_i[15]) begin
          mem_addr_o  = prg_addr;
          mem_valid_o = 1'b1;
        end
      end
      FUNC_CHR_RD: begin
        mem_addr_o  = chr_addr;
        mem_valid_o = 1'b1;
      end
      FUNC_CHR_WR: begin
        // pattern ROM blocks the write but still reports the address
        mem_addr_o  = chr_addr;
        mem_valid_o = cfg_i.chr_is_ram;
      end
      FUNC_NT: begin
        mem_addr_o  = nt_addr;
        mem_valid_o = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/cartridge_bank_mapper_with_irq_counter_core.sv -----
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_with_irq_counter_core
// Cartridge bank mapper with 16-bit IRQ down-counter, stream interface.
// ----------------------------------------------------------------------------
// Takes one bus access item per clock while the result side is not stalled,
// and returns one result item per access, in order. An accepted item sits in
// the input register while the mapper state is updated and its address
// translated, then moves into the result register, which drives m_axis_tvalid_o.
// Throughput is one item per cycle unless m_axis_tready_i stalls the result
// register. The result register decouples the sides, so a new item is taken
// into an empty input register while a finished one waits. Configuration writes are
// applied at once and belong only while no item is in flight.
`default_nettype none

module cartridge_bank_mapper_with_irq_counter_core #(
  parameter int unsigned ROM_ADDR_BITS = cbm_pkg::ROM_ADDR_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  // func[2:0], bus_addr[18:3], bus_data[26:19], zero fill
  input  wire logic [cbm_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  output logic                                    m_axis_tvalid_o,
  input  wire logic                               m_axis_tready_i,
  // mem_addr[17:0], mem_valid[18], irq_line[19], zero fill
  output logic [cbm_pkg::OUT_TDATA_W-1:0]         m_axis_tdata_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [cbm_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [cbm_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import cbm_pkg::*;

  cbm_cfg_t cfg_q;

  logic                  in_valid_q;
  logic [FUNC_W-1:0]     in_func_q;
  logic [BUS_ADDR_W-1:0] in_addr_q;
  logic [BUS_DATA_W-1:0] in_data_q;

  logic                   out_valid_q;
  logic [ADDR_W-1:0]      out_addr_q;
  logic                   out_mem_valid_q;
  logic                   out_irq_q;

  logic                   advance;
  logic                   fire;
  logic                   in_take;
  cbm_state_t             state;
  logic                   irq_level_d;
  logic [ADDR_W-1:0]      mem_addr;
  logic                   mem_valid;

  assign advance         = !out_valid_q || m_axis_tready_i;
  assign fire            = in_valid_q && advance;
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prg_mask   <= '1;
      cfg_q.chr_mask   <= '1;
      cfg_q.chr_is_ram <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_PRG_MASK:   cfg_q.prg_mask   <= cfg_data_i[ADDR_W-1:0];
        CFG_CHR_MASK:   cfg_q.chr_mask   <= cfg_data_i[ADDR_W-1:0];
        CFG_CHR_IS_RAM: cfg_q.chr_is_ram <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_func_q <= s_axis_tdata_i[FUNC_W-1:0];
      in_addr_q <= s_axis_tdata_i[FUNC_W+BUS_ADDR_W-1:FUNC_W];
      in_data_q <= s_axis_tdata_i[FUNC_W+BUS_ADDR_W+BUS_DATA_W-1:FUNC_W+BUS_ADDR_W];
    end
  end

  cbm_state u_state (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .func_i        (in_func_q),
    .bus_addr_i    (in_addr_q),
    .bus_data_i    (in_data_q),
    .state_o       (state),
    .irq_level_d_o (irq_level_d)
  );

  cbm_xlate #(
    .ROM_ADDR_BITS (ROM_ADDR_BITS)
  ) u_xlate (
    .func_i      (in_func_q),
    .bus_addr_i  (in_addr_q),
    .state_i     (state),
    .cfg_i       (cfg_q),
    .mem_addr_o  (mem_addr),
    .mem_valid_o (mem_valid)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_addr_q      <= mem_addr;
      out_mem_valid_q <= mem_valid;
      out_irq_q       <= irq_level_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OUT_TDATA_W-ADDR_W-2){1'b0}}, out_irq_q, out_mem_valid_q,
                            out_addr_q};

`ifndef NO_ASSERTIONS
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("item dropped between input and result register");

  a_irq_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> (out_irq_q == state.irq_level))
    else $error("reported irq line differs from mapper state");

  a_cpu_write_no_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (in_func_q == FUNC_CPU_WR)) |=> (!out_mem_valid_q && (out_addr_q == '0)))
    else $error("cpu register write produced a memory access");
`endif

endmodule

`default_nettype wire
